>>> rtl/mgba_pkg.sv
`timescale 1ns / 1ps

package mgba_pkg;

    localparam int NUM_AXES      = 3;
    localparam int COORD_W       = 32;
    localparam int CELL_W        = 12;
    localparam int CELLS         = 1 << CELL_W;
    localparam int SUM_W         = 48;
    localparam int CNT_W         = 24;
    localparam int CFG_IDX_W     = 3;
    localparam int DEPTH_W       = 3;
    localparam int DIMS_DEF      = 3;
    localparam int MAX_DEPTH_DEF = 4;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [CNT_W-1:0]        CNT_MAX = {CNT_W{1'b1}};

    localparam logic [COORD_W-1:0] BOUND_LOW_RST  = 32'h0000_0000;
    localparam logic [COORD_W-1:0] BOUND_HIGH_RST = 32'h0001_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_LOW      = 3'd0,
        REG_X_HIGH     = 3'd1,
        REG_Y_LOW      = 3'd2,
        REG_Y_HIGH     = 3'd3,
        REG_Z_LOW      = 3'd4,
        REG_Z_HIGH     = 3'd5,
        REG_TREE_DEPTH = 3'd6
    } t_reg_idx;

    typedef logic [NUM_AXES-1:0][COORD_W-1:0] t_axes;

    typedef struct packed {
        logic              done;
        logic              ok;
        logic [CELL_W-1:0] slot;
    } t_bin_rsp;

    typedef struct packed {
        logic                      valid;
        logic                      add;
        logic [CELL_W-1:0]         addr;
        logic signed [COORD_W-1:0] value;
    } t_store_req;

    typedef struct packed {
        logic                    valid;
        logic [CELL_W-1:0]       slot;
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
    } t_store_rsp;

endpackage

>>> rtl/mgba_bin.sv
`timescale 1ns / 1ps

module mgba_bin #(
    parameter int DIMS      = mgba_pkg::DIMS_DEF,
    parameter int MAX_DEPTH = mgba_pkg::MAX_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  mgba_pkg::t_axes               i_lo,
    input  mgba_pkg::t_axes               i_hi,
    input  mgba_pkg::t_axes               i_coord,
    input  logic [mgba_pkg::DEPTH_W-1:0]  i_depth,
    output mgba_pkg::t_bin_rsp            o_rsp
);

    localparam int NA = mgba_pkg::NUM_AXES;
    localparam int CW = mgba_pkg::COORD_W;
    localparam int XW = mgba_pkg::CELL_W;
    localparam int DW = mgba_pkg::DEPTH_W;
    localparam logic [DW-1:0] MAX_D    = DW'(MAX_DEPTH);
    localparam logic [NA-1:0] DIM_MASK = NA'((1 << DIMS) - 1);

    logic                 r_run;
    logic [DW-1:0]        r_lvl;
    logic [DW-1:0]        r_depth;
    logic                 r_ok;
    logic [XW-1:0]        r_cell;
    mgba_pkg::t_axes      r_lo;
    mgba_pkg::t_axes      r_hi;
    mgba_pkg::t_axes      r_coord;

    logic [DW-1:0]        w_depth;
    logic signed [CW:0]   w_mid_sum [NA];
    logic [CW-1:0]        w_mid     [NA];
    logic [NA-1:0]        w_lower;
    logic [NA-1:0]        w_upper;
    logic [DIMS-1:0]      w_group;
    logic                 w_fail;
    logic [XW+DIMS-1:0]   w_cat;
    logic                 w_last;

    assign w_depth = (i_depth > MAX_D) ? MAX_D : i_depth;
    assign w_last  = (r_lvl == r_depth);

    // midpoint is floor((lo + hi) / 2) at full precision
    always_comb begin
        for (int d = 0; d < NA; d++) begin
            w_mid_sum[d] = $signed({r_lo[d][CW-1], r_lo[d]}) + $signed({r_hi[d][CW-1], r_hi[d]});
            w_mid[d]     = w_mid_sum[d][CW:1];
            w_lower[d]   = ($signed(r_coord[d]) >= $signed(r_lo[d]))
                        && ($signed(r_coord[d]) <  $signed(w_mid[d]));
            w_upper[d]   = ($signed(r_coord[d]) >= $signed(w_mid[d]))
                        && ($signed(r_coord[d]) <  $signed(r_hi[d]));
        end
    end

    assign w_group = w_upper[DIMS-1:0];
    assign w_fail  = |(~(w_lower | w_upper) & DIM_MASK);
    assign w_cat   = {r_cell, w_group};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_lvl <= '0;
        end else if (i_load) begin
            r_run <= 1'b1;
            r_lvl <= '0;
        end else if (r_run) begin
            if (w_last) begin
                r_run <= 1'b0;
            end else begin
                r_lvl <= r_lvl + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_depth <= w_depth;
            r_ok    <= 1'b1;
            r_cell  <= '0;
            r_lo    <= i_lo;
            r_hi    <= i_hi;
            r_coord <= i_coord;
        end else if (r_run && !w_last) begin
            r_ok   <= r_ok & ~w_fail;
            r_cell <= w_cat[XW-1:0];
            for (int d = 0; d < NA; d++) begin
                if (w_lower[d]) begin
                    r_hi[d] <= w_mid[d];
                end
                if (w_upper[d]) begin
                    r_lo[d] <= w_mid[d];
                end
            end
        end
    end

    assign o_rsp.done = r_run & w_last;
    assign o_rsp.ok   = r_ok;
    assign o_rsp.slot = r_cell;

endmodule

>>> rtl/mgba_store.sv
`timescale 1ns / 1ps

module mgba_store (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mgba_pkg::t_store_req   i_req,
    output mgba_pkg::t_store_rsp   o_rsp,
    output logic                   o_clearing
);

    localparam int XW = mgba_pkg::CELL_W;
    localparam int SW = mgba_pkg::SUM_W;
    localparam int NW = mgba_pkg::CNT_W;
    localparam int CW = mgba_pkg::COORD_W;

    logic signed [SW-1:0] r_sum_mem [mgba_pkg::CELLS];
    logic [NW-1:0]        r_cnt_mem [mgba_pkg::CELLS];

    logic                 r_clr;
    logic [XW-1:0]        r_clr_addr;
    logic                 r_pend;
    logic                 r_add;
    logic [XW-1:0]        r_addr;
    logic signed [CW-1:0] r_val;
    logic signed [SW-1:0] r_sum_q;
    logic [NW-1:0]        r_cnt_q;

    logic signed [SW:0]   w_sum_ext;
    logic signed [SW-1:0] n_sum;
    logic [NW-1:0]        n_cnt;
    logic                 w_we;
    logic [XW-1:0]        w_waddr;
    logic signed [SW-1:0] w_wsum;
    logic [NW-1:0]        w_wcnt;

    // saturating add on the entry just read
    assign w_sum_ext = $signed({r_sum_q[SW-1], r_sum_q})
                     + $signed({{(SW+1-CW){r_val[CW-1]}}, r_val});
    assign n_sum = (w_sum_ext[SW] != w_sum_ext[SW-1])
                 ? (w_sum_ext[SW] ? mgba_pkg::SUM_MIN : mgba_pkg::SUM_MAX)
                 : w_sum_ext[SW-1:0];
    assign n_cnt = (r_cnt_q == mgba_pkg::CNT_MAX) ? r_cnt_q : r_cnt_q + 1'b1;

    assign w_we    = r_clr | (r_pend & r_add);
    assign w_waddr = r_clr ? r_clr_addr : r_addr;
    assign w_wsum  = r_clr ? '0 : n_sum;
    assign w_wcnt  = r_clr ? '0 : n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_pend     <= 1'b0;
        end else begin
            r_pend <= i_req.valid;
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    r_clr <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_add  <= i_req.add;
            r_addr <= i_req.addr;
            r_val  <= i_req.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_sum_mem[w_waddr] <= w_wsum;
            r_cnt_mem[w_waddr] <= w_wcnt;
        end
        if (i_req.valid) begin
            r_sum_q <= r_sum_mem[i_req.addr];
            r_cnt_q <= r_cnt_mem[i_req.addr];
        end
    end

    assign o_rsp.valid = r_pend;
    assign o_rsp.slot  = r_addr;
    assign o_rsp.sum   = r_add ? n_sum : r_sum_q;
    assign o_rsp.count = r_add ? n_cnt : r_cnt_q;
    assign o_clearing  = r_clr;

endmodule

>>> rtl/multidim_grid_binning_accumulator_core.sv
`timescale 1ns / 1ps
// add: the depth (clamped to MAX_DEPTH) sets how many binning levels run before the strobe;
//   one binning level per cycle, a memory read, a read-modify-write, then the result register
// read: result strobe after a memory read and then the result register
// next start is taken in the strobe cycle, for add, drop and read alike
// synchronous reset clears control and config, then a store clear of every cell holds busy
// results are one-cycle strobes; the receiver cannot stall

module multidim_grid_binning_accumulator_core #(
    parameter int DIMS      = mgba_pkg::DIMS_DEF,
    parameter int MAX_DEPTH = mgba_pkg::MAX_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic                                  i_func,
    input  logic signed [mgba_pkg::COORD_W-1:0]   i_x_coord,
    input  logic signed [mgba_pkg::COORD_W-1:0]   i_y_coord,
    input  logic signed [mgba_pkg::COORD_W-1:0]   i_z_coord,
    input  logic signed [mgba_pkg::COORD_W-1:0]   i_sample_value,
    input  logic [mgba_pkg::CELL_W-1:0]           i_cell_select,
    input  logic                                  i_cfg_we,
    input  logic [mgba_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mgba_pkg::COORD_W-1:0]          i_cfg_data,
    output logic                                  o_valid,
    output logic                                  o_in_range,
    output logic [mgba_pkg::CELL_W-1:0]           o_landed_cell,
    output logic signed [mgba_pkg::SUM_W-1:0]     o_cell_sum,
    output logic [mgba_pkg::CNT_W-1:0]            o_cell_count
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_BIN  = 3'b010,
        S_MEM  = 3'b100
    } t_state;

    t_state                              r_state;
    t_state                              n_state;
    mgba_pkg::t_axes                     r_lo;
    mgba_pkg::t_axes                     r_hi;
    logic [mgba_pkg::DEPTH_W-1:0]        r_depth;
    logic signed [mgba_pkg::COORD_W-1:0] r_value;

    logic                                r_valid;
    logic                                r_in_range;
    logic [mgba_pkg::CELL_W-1:0]         r_landed_cell;
    logic signed [mgba_pkg::SUM_W-1:0]   r_cell_sum;
    logic [mgba_pkg::CNT_W-1:0]          r_cell_count;

    logic                                w_accept;
    logic                                w_clearing;
    mgba_pkg::t_axes                     w_coord;
    mgba_pkg::t_bin_rsp                  w_bin;
    mgba_pkg::t_store_req                w_req;
    mgba_pkg::t_store_rsp                w_rsp;

    assign o_busy   = (r_state != S_IDLE) | w_clearing;
    assign w_accept = i_start & ~o_busy;
    assign w_coord  = {i_z_coord, i_y_coord, i_x_coord};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo    <= {mgba_pkg::NUM_AXES{mgba_pkg::BOUND_LOW_RST}};
            r_hi    <= {mgba_pkg::NUM_AXES{mgba_pkg::BOUND_HIGH_RST}};
            r_depth <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mgba_pkg::REG_X_LOW:      r_lo[0] <= i_cfg_data;
                mgba_pkg::REG_X_HIGH:     r_hi[0] <= i_cfg_data;
                mgba_pkg::REG_Y_LOW:      r_lo[1] <= i_cfg_data;
                mgba_pkg::REG_Y_HIGH:     r_hi[1] <= i_cfg_data;
                mgba_pkg::REG_Z_LOW:      r_lo[2] <= i_cfg_data;
                mgba_pkg::REG_Z_HIGH:     r_hi[2] <= i_cfg_data;
                mgba_pkg::REG_TREE_DEPTH: r_depth <= i_cfg_data[mgba_pkg::DEPTH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mgba_bin #(
        .DIMS      (DIMS),
        .MAX_DEPTH (MAX_DEPTH)
    ) u_bin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept & ~i_func),
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .i_coord (w_coord),
        .i_depth (r_depth),
        .o_rsp   (w_bin)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value <= i_sample_value;
        end
    end

    always_comb begin
        w_req.valid = 1'b0;
        w_req.add   = 1'b0;
        w_req.addr  = i_cell_select;
        w_req.value = r_value;
        n_state     = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_func) begin
                        w_req.valid = 1'b1;
                        n_state     = S_MEM;
                    end else begin
                        n_state = S_BIN;
                    end
                end
            end
            S_BIN: begin
                w_req.add  = 1'b1;
                w_req.addr = w_bin.slot;
                if (w_bin.done) begin
                    w_req.valid = w_bin.ok;
                    n_state     = w_bin.ok ? S_MEM : S_IDLE;
                end
            end
            S_MEM: begin
                if (w_rsp.valid) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    mgba_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .o_rsp      (w_rsp),
        .o_clearing (w_clearing)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= w_rsp.valid | ((r_state == S_BIN) & w_bin.done & ~w_bin.ok);
        end
    end

    // dropped sample beats carry all-zero fields
    always_ff @(posedge i_clk) begin
        if (w_rsp.valid) begin
            r_in_range    <= 1'b1;
            r_landed_cell <= w_rsp.slot;
            r_cell_sum    <= w_rsp.sum;
            r_cell_count  <= w_rsp.count;
        end else if ((r_state == S_BIN) && w_bin.done && !w_bin.ok) begin
            r_in_range    <= 1'b0;
            r_landed_cell <= '0;
            r_cell_sum    <= '0;
            r_cell_count  <= '0;
        end
    end

    assign o_valid       = r_valid;
    assign o_in_range    = r_in_range;
    assign o_landed_cell = r_landed_cell;
    assign o_cell_sum    = r_cell_sum;
    assign o_cell_count  = r_cell_count;

`ifndef SYNTH
    a_req_not_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.valid |-> !w_clearing)
        else $error("store access during clear");

    a_rsp_in_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.valid |-> (r_state == S_MEM))
        else $error("store response outside memory state");

    a_valid_follows_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) != S_IDLE))
        else $error("result beat without work in progress");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_range) |->
            (o_landed_cell == '0 && o_cell_sum == '0 && o_cell_count == '0))
        else $error("dropped sample beat with nonzero fields");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int NUM_AXES    = mgba_pkg::NUM_AXES;
    localparam int COORD_W     = mgba_pkg::COORD_W;
    localparam int CELL_W      = mgba_pkg::CELL_W;
    localparam int CELLS       = mgba_pkg::CELLS;
    localparam int SUM_W       = mgba_pkg::SUM_W;
    localparam int CNT_W       = mgba_pkg::CNT_W;
    localparam int CFG_IDX_W   = mgba_pkg::CFG_IDX_W;
    localparam int DEPTH_W     = mgba_pkg::DEPTH_W;
    localparam int DIMS        = mgba_pkg::DIMS_DEF;
    localparam int MAX_DEPTH   = mgba_pkg::MAX_DEPTH_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 150;
    localparam int REPORT_MAX  = 10;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic                    in_range;
        logic [CELL_W-1:0]       slot;
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
    } t_bin_result;

    typedef struct {
        logic                      func;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] value;
        logic [CELL_W-1:0]         sel;
    } t_sample;

    typedef enum {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        mgba_pkg::t_reg_idx idx;
        logic [COORD_W-1:0] data;
        t_sample            s;
        logic               pinned;
        t_bin_result        res;
    } t_plan_row;

    localparam t_bin_result DROPPED = '0;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_start = 1'b0;
    logic                      i_func = 1'b0;
    logic signed [COORD_W-1:0] i_x_coord = '0;
    logic signed [COORD_W-1:0] i_y_coord = '0;
    logic signed [COORD_W-1:0] i_z_coord = '0;
    logic signed [COORD_W-1:0] i_sample_value = '0;
    logic [CELL_W-1:0]         i_cell_select = '0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [COORD_W-1:0]        i_cfg_data = '0;
    logic                      o_busy;
    logic                      o_valid;
    logic                      o_in_range;
    logic [CELL_W-1:0]         o_landed_cell;
    logic signed [SUM_W-1:0]   o_cell_sum;
    logic [CNT_W-1:0]          o_cell_count;

    logic        pin_valid = 1'b0;
    t_bin_result pin_res = '0;

    logic signed [COORD_W-1:0] axis_low [NUM_AXES];
    logic signed [COORD_W-1:0] axis_high [NUM_AXES];
    logic [DEPTH_W-1:0]        levels_cfg;
    logic signed [SUM_W-1:0]   sum_tab [CELLS];
    logic [CNT_W-1:0]          count_tab [CELLS];

    t_bin_result result_q [$];
    t_plan_row   plan [$];
    int          fail_count = 0;
    int          stall_cycles = 0;
    int          burst_left = 0;

    multidim_grid_binning_accumulator_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_func         (i_func),
        .i_x_coord      (i_x_coord),
        .i_y_coord      (i_y_coord),
        .i_z_coord      (i_z_coord),
        .i_sample_value (i_sample_value),
        .i_cell_select  (i_cell_select),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_in_range     (o_in_range),
        .o_landed_cell  (o_landed_cell),
        .o_cell_sum     (o_cell_sum),
        .o_cell_count   (o_cell_count)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_bin_result bin_and_accumulate(input t_sample s);
        t_bin_result r;
        longint      lo [NUM_AXES];
        longint      hi [NUM_AXES];
        longint      pos [NUM_AXES];
        longint      mid;
        longint      acc;
        int          levels;
        logic [CELL_W-1:0] slot;
        logic [NUM_AXES-1:0] group;
        logic        ok;
        r = '0;
        slot = '0;
        if (s.func == FUNC_READ) begin
            slot = s.sel;
        end else begin
            levels = (levels_cfg > MAX_DEPTH) ? MAX_DEPTH : levels_cfg;
            pos[0] = s.x;
            pos[1] = s.y;
            pos[2] = s.z;
            for (int d = 0; d < NUM_AXES; d++) begin
                lo[d] = axis_low[d];
                hi[d] = axis_high[d];
            end
            ok = 1'b1;
            for (int lvl = 0; lvl < levels && ok; lvl++) begin
                group = '0;
                for (int d = 0; d < DIMS && ok; d++) begin
                    mid = (lo[d] + hi[d]) >>> 1;
                    if (pos[d] >= lo[d] && pos[d] < mid) begin
                        hi[d] = mid;
                    end else if (pos[d] >= mid && pos[d] < hi[d]) begin
                        lo[d] = mid;
                        group[d] = 1'b1;
                    end else begin
                        ok = 1'b0;
                    end
                end
                slot = CELL_W'((slot << DIMS) | group);
            end
            if (!ok)
                return DROPPED;
            acc = sum_tab[slot] + s.value;
            if (acc > mgba_pkg::SUM_MAX)
                acc = mgba_pkg::SUM_MAX;
            if (acc < mgba_pkg::SUM_MIN)
                acc = mgba_pkg::SUM_MIN;
            sum_tab[slot] = SUM_W'(acc);
            if (count_tab[slot] != mgba_pkg::CNT_MAX)
                count_tab[slot] = count_tab[slot] + 1'b1;
        end
        r.in_range = 1'b1;
        r.slot = slot;
        r.sum = sum_tab[slot];
        r.count = count_tab[slot];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_bin_result want;
        t_bin_result got;
        t_sample     s;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) begin
                sum_tab[i] = '0;
                count_tab[i] = '0;
            end
            for (int d = 0; d < NUM_AXES; d++) begin
                axis_low[d] = mgba_pkg::BOUND_LOW_RST;
                axis_high[d] = mgba_pkg::BOUND_HIGH_RST;
            end
            levels_cfg = '0;
        end else begin
            if (o_valid) begin
                got = {o_in_range, o_landed_cell, o_cell_sum, o_cell_count};
                if (result_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("unexpected beat: in_range=%0d cell=%0d sum=%0d count=%0d",
                                 got.in_range, got.slot, got.sum, got.count);
                end else begin
                    want = result_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display({"mismatch: expected in_range=%0d cell=%0d sum=%0d ",
                                      "count=%0d, got in_range=%0d cell=%0d sum=%0d count=%0d"},
                                     want.in_range, want.slot, want.sum, want.count,
                                     got.in_range, got.slot, got.sum, got.count);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mgba_pkg::REG_X_LOW:      axis_low[0] = i_cfg_data;
                    mgba_pkg::REG_X_HIGH:     axis_high[0] = i_cfg_data;
                    mgba_pkg::REG_Y_LOW:      axis_low[1] = i_cfg_data;
                    mgba_pkg::REG_Y_HIGH:     axis_high[1] = i_cfg_data;
                    mgba_pkg::REG_Z_LOW:      axis_low[2] = i_cfg_data;
                    mgba_pkg::REG_Z_HIGH:     axis_high[2] = i_cfg_data;
                    mgba_pkg::REG_TREE_DEPTH: levels_cfg = i_cfg_data[DEPTH_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !o_busy) begin
                s.func = i_func;
                s.x = i_x_coord;
                s.y = i_y_coord;
                s.z = i_z_coord;
                s.value = i_sample_value;
                s.sel = i_cell_select;
                want = bin_and_accumulate(s);
                result_q.insert(result_q.size(), pin_valid ? pin_res : want);
            end
        end
        if ((i_start && !o_busy) || o_valid)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic t_sample smp(input logic f, input logic [COORD_W-1:0] x, y, z, v,
                                    input logic [CELL_W-1:0] sel);
        t_sample s;
        s.func = f;
        s.x = x;
        s.y = y;
        s.z = z;
        s.value = v;
        s.sel = sel;
        return s;
    endfunction

    function automatic t_bin_result exp_res(input logic rng, input logic [CELL_W-1:0] slot,
                                            input longint sum, input int count);
        t_bin_result r;
        r.in_range = rng;
        r.slot = slot;
        r.sum = SUM_W'(sum);
        r.count = CNT_W'(count);
        return r;
    endfunction

    function automatic void cfg_row(input mgba_pkg::t_reg_idx idx,
                                    input logic [COORD_W-1:0] data);
        t_plan_row r;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        r.pinned = 1'b0;
        r.res = '0;
        plan.insert(plan.size(), r);
    endfunction

    function automatic void pinned_row(input t_sample s, input logic pin, input t_bin_result res);
        t_plan_row r;
        r.kind = ROW_ITEM;
        r.idx = mgba_pkg::REG_X_LOW;
        r.data = '0;
        r.s = s;
        r.pinned = pin;
        r.res = res;
        plan.insert(plan.size(), r);
    endfunction

    function automatic void item_row(input t_sample s);
        pinned_row(s, 1'b0, DROPPED);
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input int d);
        longint lo;
        longint hi;
        lo = axis_low[d];
        hi = axis_high[d];
        case ($urandom_range(0, 19))
            0: return $urandom;
            1: return COORD_W'(lo);
            2: return COORD_W'(hi - 1);
            3: return COORD_W'(hi);
            4: return COORD_W'(lo - 1);
            5: return COORD_W'((lo + hi) >>> 1);
            default: begin
                if (hi > lo)
                    return COORD_W'(lo + (longint'($urandom) % (hi - lo)));
                return $urandom;
            end
        endcase
    endfunction

    function automatic t_sample random_sample();
        t_sample s;
        int      levels;
        levels = (levels_cfg > MAX_DEPTH) ? MAX_DEPTH : levels_cfg;
        s.func = ($urandom_range(0, 4) == 0) ? FUNC_READ : FUNC_ADD;
        s.x = pick_coord(0);
        s.y = pick_coord(1);
        s.z = pick_coord(2);
        case ($urandom_range(0, 7))
            0: s.value = COORD_MAX;
            1: s.value = COORD_MIN;
            default: s.value = $urandom;
        endcase
        s.sel = $urandom;
        if ($urandom_range(0, 1) == 1)
            s.sel = s.sel & CELL_W'((1 << (DIMS * levels)) - 1);
        return s;
    endfunction

    task automatic pick_bounds(input int mode, output logic [COORD_W-1:0] lo, hi);
        longint a;
        longint b;
        case (mode)
            0, 1: begin
                lo = mgba_pkg::BOUND_LOW_RST;
                hi = mgba_pkg::BOUND_HIGH_RST;
            end
            2, 3: begin
                lo = COORD_MIN;
                hi = COORD_MAX;
            end
            4, 5, 6: begin
                a = longint'(signed'($urandom));
                b = longint'(signed'($urandom));
                lo = COORD_W'((a < b) ? a : b);
                hi = COORD_W'((a < b) ? b : a);
            end
            7, 8: begin
                a = longint'(signed'($urandom));
                if (a > longint'(COORD_MAX) - 64)
                    a = a - 64;
                lo = COORD_W'(a);
                hi = COORD_W'(a + $urandom_range(1, 64));
            end
            9, 10: begin
                a = -65536 * longint'($urandom_range(1, 100));
                lo = COORD_W'(a);
                hi = COORD_W'(a + 65536 * longint'($urandom_range(1, 200)));
            end
            default: begin
                lo = $urandom;
                hi = lo - $urandom_range(0, 5);
            end
        endcase
    endtask

    task automatic settle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (result_q.size() != 0 || o_busy)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input mgba_pkg::t_reg_idx idx, input logic [COORD_W-1:0] data);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(input t_sample s, input logic pin, input t_bin_result res);
        i_func <= s.func;
        i_x_coord <= s.x;
        i_y_coord <= s.y;
        i_z_coord <= s.z;
        i_sample_value <= s.value;
        i_cell_select <= s.sel;
        pin_valid <= pin;
        pin_res <= res;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
    endtask

    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(0, 15);
        end
    endtask

    initial begin
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
        int                 mode;
        int                 levels;

        // reset config: whole space is cell 0
        pinned_row(smp(FUNC_READ, 0, 0, 0, 0, 12'h000), 1'b1, exp_res(1'b1, 12'h000, 0, 0));
        pinned_row(smp(FUNC_READ, 0, 0, 0, 0, 12'hfff), 1'b1, exp_res(1'b1, 12'hfff, 0, 0));
        pinned_row(smp(FUNC_ADD, COORD_MIN, COORD_MAX, 0, COORD_MAX, 12'hfff),
                   1'b1, exp_res(1'b1, 12'h000, 2147483647, 1));
        pinned_row(smp(FUNC_ADD, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, 0),
                   1'b1, exp_res(1'b1, 12'h000, -1, 2));
        // depth above the maximum is clamped
        cfg_row(mgba_pkg::REG_TREE_DEPTH, 7);
        item_row(smp(FUNC_ADD, 0, 0, 0, 1, 0));
        item_row(smp(FUNC_ADD, 65535, 65535, 65535, -5, 0));
        pinned_row(smp(FUNC_ADD, 65536, 0, 0, 9, 0), 1'b1, DROPPED);
        pinned_row(smp(FUNC_ADD, 0, -1, 0, 9, 0), 1'b1, DROPPED);
        item_row(smp(FUNC_ADD, 32767, 32768, 16384, 7, 0));
        item_row(smp(FUNC_READ, 0, 0, 0, 0, 12'hfff));
        // empty and inverted intervals
        cfg_row(mgba_pkg::REG_X_LOW, COORD_MIN);
        cfg_row(mgba_pkg::REG_X_HIGH, COORD_MAX);
        cfg_row(mgba_pkg::REG_Y_LOW, 100);
        cfg_row(mgba_pkg::REG_Y_HIGH, 100);
        cfg_row(mgba_pkg::REG_Z_LOW, COORD_MIN);
        cfg_row(mgba_pkg::REG_Z_HIGH, COORD_MAX);
        cfg_row(mgba_pkg::REG_TREE_DEPTH, 1);
        pinned_row(smp(FUNC_ADD, 0, 100, 0, 3, 0), 1'b1, DROPPED);
        cfg_row(mgba_pkg::REG_Y_LOW, 200);
        pinned_row(smp(FUNC_ADD, 0, 150, 0, 3, 0), 1'b1, DROPPED);
        // full range, upper bound excluded
        cfg_row(mgba_pkg::REG_Y_LOW, COORD_MIN);
        cfg_row(mgba_pkg::REG_Y_HIGH, COORD_MAX);
        item_row(smp(FUNC_ADD, COORD_MIN, COORD_MAX - 1, -1, COORD_MAX, 0));
        pinned_row(smp(FUNC_ADD, COORD_MAX, 0, 0, 3, 0), 1'b1, DROPPED);
        item_row(smp(FUNC_ADD, -1, -2, -1, COORD_MIN, 0));
        // tiny interval narrows to nothing
        cfg_row(mgba_pkg::REG_TREE_DEPTH, 2);
        cfg_row(mgba_pkg::REG_X_LOW, 0);
        cfg_row(mgba_pkg::REG_X_HIGH, 3);
        item_row(smp(FUNC_ADD, 0, 0, 0, 11, 0));
        item_row(smp(FUNC_ADD, 2, COORD_MIN, COORD_MAX - 1, 12, 0));
        pinned_row(smp(FUNC_ADD, 3, 0, 0, 1, 0), 1'b1, DROPPED);
        cfg_row(mgba_pkg::REG_TREE_DEPTH, 4);
        cfg_row(mgba_pkg::REG_X_HIGH, 65536);
        item_row(smp(FUNC_ADD, 65535, COORD_MIN, COORD_MIN, -1, 0));
        item_row(smp(FUNC_READ, 0, 0, 0, 0, 12'h924));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                send_item(plan[i].s, plan[i].pinned, plan[i].res);
                pace();
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            for (int d = 0; d < NUM_AXES; d++) begin
                case (ph)
                    0: mode = 2;
                    1, 2: mode = 0;
                    default: mode = $urandom_range(0, 11);
                endcase
                pick_bounds(mode, lo, hi);
                write_reg(mgba_pkg::t_reg_idx'(2 * d), lo);
                write_reg(mgba_pkg::t_reg_idx'(2 * d + 1), hi);
            end
            case (ph)
                0: levels = MAX_DEPTH;
                1: levels = 0;
                2: levels = 7;
                3: levels = 1;
                default: levels = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                               : $urandom_range(1, MAX_DEPTH);
            endcase
            write_reg(mgba_pkg::REG_TREE_DEPTH, levels);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(random_sample(), 1'b0, DROPPED);
                pace();
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && result_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
